@@ rtl/prfu_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prfu_pkg: shared types and constants of the base relocation fixup unit
// Holds the register indexes, the entry type codes, the access width codes,
// the status codes and the command that travels from the parser to the
// fixup stage.
// ----------------------------------------------------------------------------
package prfu_pkg;

  localparam int DELTA_W = 64;
  localparam int ADDR_W  = 32;
  localparam int HALF_W  = 16;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOAD_DELTA     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_SIZE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RELOC_DIR_SIZE = 2'd2;

  localparam logic [3:0] TYPE_ABSOLUTE = 4'd0;
  localparam logic [3:0] TYPE_HIGH     = 4'd1;
  localparam logic [3:0] TYPE_LOW      = 4'd2;
  localparam logic [3:0] TYPE_HIGHLOW  = 4'd3;
  localparam logic [3:0] TYPE_DIR64    = 4'd10;

  localparam logic [1:0] ACC_NONE = 2'd0;
  localparam logic [1:0] ACC_16   = 2'd1;
  localparam logic [1:0] ACC_32   = 2'd2;
  localparam logic [1:0] ACC_64   = 2'd3;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [2:0] {
    ST_OK,
    ST_BAD_TYPE,
    ST_BAD_SIZE,
    ST_OUT_OF_BOUNDS,
    ST_TRUNCATED
  } status_e;

  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_HIGH,
    KIND_LOW,
    KIND_HIGHLOW,
    KIND_DIR64
  } fix_kind_e;

  typedef struct packed {
    logic [ADDR_W-1:0] target;
    fix_kind_e         kind;
    status_e           status;
    logic              last;
  } cmd_t;

endpackage

@@ rtl/prfu_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prfu_front: relocation stream parser
// Gathers each block header, decodes the entries, checks block sizes, types
// and bounds, and issues one command per result into the command queue.
// ----------------------------------------------------------------------------
module prfu_front import prfu_pkg::*; #(
  parameter int AddrBits = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [HALF_W-1:0] rel_half_i,
  input  logic              region_end_i,
  input  logic              delta_zero_i,
  input  logic [31:0]       image_size_i,
  input  logic [31:0]       reloc_dir_size_i,
  input  logic              q_full_i,
  output logic              push_o,
  output cmd_t              cmd_o
);

  typedef enum logic [2:0] {
    PH_PAGE_LO,
    PH_PAGE_HI,
    PH_SIZE_LO,
    PH_SIZE_HI,
    PH_ENTRY
  } phase_e;

  localparam int TgtBits = (AddrBits < ADDR_W) ? AddrBits : ADDR_W;
  localparam logic [ADDR_W-1:0] TgtMask = {ADDR_W{1'b1}} >> (ADDR_W - TgtBits);

  phase_e      phase_q, phase_d;
  logic [31:0] page_q, page_d;
  logic [31:0] size_q, size_d;
  logic [30:0] entries_q, entries_d;
  logic        halted_q, halted_d;

  logic        accept;
  logic [31:0] size_new;
  logic [31:0] size_sub;
  logic [11:0] offset;
  logic [3:0]  etype;
  logic [3:0]  nbytes;
  logic [32:0] sum;
  logic [33:0] sum_end;
  fix_kind_e   kind;
  status_e     err;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign offset     = rel_half_i[11:0];
  assign etype      = rel_half_i[15:12];
  assign size_new   = {rel_half_i, size_q[15:0]};
  assign size_sub   = size_new - 32'd8;
  assign sum        = {1'b0, page_q} + {21'b0, offset};

  always_comb begin
    phase_d   = phase_q;
    page_d    = page_q;
    size_d    = size_q;
    entries_d = entries_q;
    halted_d  = halted_q;
    push_o    = 1'b0;
    cmd_o     = '{target: '0, kind: KIND_NONE, status: ST_OK, last: 1'b0};
    kind      = KIND_NONE;
    nbytes    = 4'd0;
    sum_end   = '0;
    err       = ST_OK;
    if (accept && !halted_q) begin
      if (delta_zero_i) begin
        if (region_end_i) begin
          phase_d   = PH_PAGE_LO;
          page_d    = '0;
          size_d    = '0;
          entries_d = '0;
          push_o    = 1'b1;
          cmd_o.last = 1'b1;
        end
      end else begin
        unique case (phase_q)
          PH_PAGE_LO: begin
            page_d  = {16'b0, rel_half_i};
            phase_d = PH_PAGE_HI;
          end
          PH_PAGE_HI: begin
            page_d  = {rel_half_i, page_q[15:0]};
            phase_d = PH_SIZE_LO;
          end
          PH_SIZE_LO: begin
            size_d  = {16'b0, rel_half_i};
            phase_d = PH_SIZE_HI;
          end
          PH_SIZE_HI: begin
            size_d = size_new;
            if (size_new < 32'd8 || size_new[0] || size_new > reloc_dir_size_i) begin
              err = ST_BAD_SIZE;
            end else begin
              entries_d = size_sub[31:1];
              phase_d   = (size_sub[31:1] != 31'd0) ? PH_ENTRY : PH_PAGE_LO;
            end
          end
          PH_ENTRY: begin
            entries_d = entries_q - 31'd1;
            if (entries_d == 31'd0) begin
              phase_d = PH_PAGE_LO;
            end
            unique case (etype)
              TYPE_ABSOLUTE: kind = KIND_NONE;
              TYPE_HIGH: begin
                kind   = KIND_HIGH;
                nbytes = 4'd2;
              end
              TYPE_LOW: begin
                kind   = KIND_LOW;
                nbytes = 4'd2;
              end
              TYPE_HIGHLOW: begin
                kind   = KIND_HIGHLOW;
                nbytes = 4'd4;
              end
              TYPE_DIR64: begin
                kind   = KIND_DIR64;
                nbytes = 4'd8;
              end
              default: err = ST_BAD_TYPE;
            endcase
            sum_end = {1'b0, sum} + {30'b0, nbytes};
            if (err == ST_OK && kind != KIND_NONE && sum_end > {2'b0, image_size_i}) begin
              err = ST_OUT_OF_BOUNDS;
            end
          end
          default: phase_d = PH_PAGE_LO;
        endcase

        if (err != ST_OK) begin
          halted_d     = 1'b1;
          push_o       = 1'b1;
          cmd_o.status = err;
          cmd_o.last   = 1'b1;
        end else if (region_end_i) begin
          push_o     = 1'b1;
          cmd_o.last = 1'b1;
          if (phase_d != PH_PAGE_LO) begin
            halted_d     = 1'b1;
            cmd_o.status = ST_TRUNCATED;
          end else begin
            phase_d      = PH_PAGE_LO;
            page_d       = '0;
            size_d       = '0;
            entries_d    = '0;
            cmd_o.kind   = kind;
            cmd_o.target = (kind != KIND_NONE) ? (sum[31:0] & TgtMask) : '0;
          end
        end else if (kind != KIND_NONE) begin
          push_o       = 1'b1;
          cmd_o.kind   = kind;
          cmd_o.target = sum[31:0] & TgtMask;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_PAGE_LO;
      page_q    <= '0;
      size_q    <= '0;
      entries_q <= '0;
      halted_q  <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      page_q    <= page_d;
      size_q    <= size_d;
      entries_q <= entries_d;
      halted_q  <= halted_d;
    end
  end

endmodule

@@ rtl/prfu_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prfu_queue: command queue
// A short first-in first-out queue of parser commands that lets the parser
// and the fixup stage stall independently.
// ----------------------------------------------------------------------------
module prfu_queue import prfu_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  output logic empty_o,
  input  logic pop_i,
  output cmd_t cmd_o
);

  cmd_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              do_push;
  logic              do_pop;

  assign full_o  = (count_q == QCNT_W'(QDEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

@@ rtl/prfu_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prfu_back: fixup command builder
// Takes commands from the queue, derives the access width and the addend
// from the load delta and holds the result in the output register.
// ----------------------------------------------------------------------------
module prfu_back import prfu_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_empty_i,
  input  cmd_t               cmd_i,
  output logic               pop_o,
  input  logic [DELTA_W-1:0] load_delta_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [ADDR_W-1:0]  target_addr_o,
  output logic [1:0]         access_width_o,
  output logic [DELTA_W-1:0] addend_o,
  output logic [2:0]         status_o,
  output logic               final_res_o
);

  logic               valid_q;
  logic [ADDR_W-1:0]  target_q;
  logic [1:0]         width_q, width_d;
  logic [DELTA_W-1:0] addend_q, addend_d;
  status_e            status_q;
  logic               last_q;

  assign pop_o = !q_empty_i && (!valid_q || out_ready_i);

  always_comb begin
    unique case (cmd_i.kind)
      KIND_HIGH: begin
        width_d  = ACC_16;
        addend_d = {48'b0, load_delta_i[31:16]};
      end
      KIND_LOW: begin
        width_d  = ACC_16;
        addend_d = {48'b0, load_delta_i[15:0]};
      end
      KIND_HIGHLOW: begin
        width_d  = ACC_32;
        addend_d = {32'b0, load_delta_i[31:0]};
      end
      KIND_DIR64: begin
        width_d  = ACC_64;
        addend_d = load_delta_i;
      end
      default: begin
        width_d  = ACC_NONE;
        addend_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      target_q <= cmd_i.target;
      width_q  <= width_d;
      addend_q <= addend_d;
      status_q <= cmd_i.status;
      last_q   <= cmd_i.last;
    end
  end

  assign out_valid_o    = valid_q;
  assign target_addr_o  = target_q;
  assign access_width_o = width_q;
  assign addend_o       = addend_q;
  assign status_o       = status_q;
  assign final_res_o    = last_q;

endmodule

@@ rtl/pe_base_relocation_fixup_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pe_base_relocation_fixup_unit: base relocation fixup engine
// The relocation region enters one halfword per beat on the input channel
// (rel_half_i, region_end_i on the last halfword). Each block header is a
// page address and a block size, two halfwords each, low half first; each
// entry then yields at most one fixup command on the output channel with its
// target, access width, addend, status and final flag. Errors give one final
// result with a non-zero status, after which input beats are consumed but
// produce nothing until reset. The user writes the load delta, the image size
// and the relocation directory size on the configuration channel while idle
// only; the unit does not enforce it. A halfword is taken every cycle while
// the queue has room; each result is registered in the command queue, then in
// the output register. When the receiver stalls, the two-entry command queue
// fills and the input channel then stalls. Reset clears the configuration
// registers, the parser state and the halt flag; no clearing pass is needed.
// ----------------------------------------------------------------------------
module pe_base_relocation_fixup_unit import prfu_pkg::*; #(
  parameter int ADDR_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DELTA_W-1:0]   cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [HALF_W-1:0]    rel_half_i,
  input  logic                 region_end_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [ADDR_W-1:0]    target_addr_o,
  output logic [1:0]           access_width_o,
  output logic [DELTA_W-1:0]   addend_o,
  output logic [2:0]           status_o,
  output logic                 final_res_o
);

  logic [DELTA_W-1:0] load_delta_q;
  logic [31:0]        image_size_q;
  logic [31:0]        reloc_dir_size_q;

  logic push;
  logic pop;
  logic q_full;
  logic q_empty;
  cmd_t cmd_in;
  cmd_t cmd_out;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_delta_q     <= '0;
      image_size_q     <= '0;
      reloc_dir_size_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_LOAD_DELTA:     load_delta_q     <= cfg_data_i;
        CFG_IMAGE_SIZE:     image_size_q     <= cfg_data_i[31:0];
        CFG_RELOC_DIR_SIZE: reloc_dir_size_q <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  prfu_front #(
    .AddrBits(ADDR_BITS)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .rel_half_i      (rel_half_i),
    .region_end_i    (region_end_i),
    .delta_zero_i    (load_delta_q == '0),
    .image_size_i    (image_size_q),
    .reloc_dir_size_i(reloc_dir_size_q),
    .q_full_i        (q_full),
    .push_o          (push),
    .cmd_o           (cmd_in)
  );

  prfu_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (cmd_in),
    .full_o (q_full),
    .empty_o(q_empty),
    .pop_i  (pop),
    .cmd_o  (cmd_out)
  );

  prfu_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_empty),
    .cmd_i         (cmd_out),
    .pop_o         (pop),
    .load_delta_i  (load_delta_q),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .target_addr_o (target_addr_o),
    .access_width_o(access_width_o),
    .addend_o      (addend_o),
    .status_o      (status_o),
    .final_res_o   (final_res_o)
  );

endmodule

@@ verif/pe_base_relocation_fixup_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pe_base_relocation_fixup_unit_tb: self-checking bench for the fixup unit
// Streams relocation regions into the unit halfword by halfword and predicts
// every fixup command, empty final result and error from its own model of
// the block parser. A directed region covers every entry type and the address
// extremes. Random phases of well-formed blocks, or of random halfwords for a
// zero load delta, follow under several register settings. The run closes
// with one randomly chosen error, since an error halts the unit until reset.
// ----------------------------------------------------------------------------
module pe_base_relocation_fixup_unit_tb;
  import prfu_pkg::*;

  localparam int unsigned TIMEOUT_CYCLES = 200000;
  localparam int PHASE_BEATS = 110;
  localparam int SETTLE_CYCLES = 8;
  localparam int REPORT_LIMIT = 10;

  typedef enum logic [2:0] {
    HDR_PAGE_LO,
    HDR_PAGE_HI,
    HDR_SIZE_LO,
    HDR_SIZE_HI,
    HDR_ENTRIES
  } hdr_phase_e;

  typedef struct {
    logic [ADDR_W-1:0]  target;
    logic [1:0]         width;
    logic [DELTA_W-1:0] addend;
    status_e            status;
    logic               done;
  } fixup_t;

  class reloc_fixup_scoreboard;
    logic [DELTA_W-1:0] load_delta;
    logic [31:0]        image_size;
    logic [31:0]        dir_size;
    hdr_phase_e         phase;
    logic [31:0]        page_addr;
    logic [31:0]        block_size;
    logic [30:0]        entries_left;
    bit                 halted;
    fixup_t             expected_fixups[$];
    int                 mismatches;

    function new();
      load_delta = '0;
      image_size = '0;
      dir_size = '0;
      halted = 1'b0;
      mismatches = 0;
      clear_parser();
    endfunction

    function void clear_parser();
      phase = HDR_PAGE_LO;
      page_addr = '0;
      block_size = '0;
      entries_left = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [DELTA_W-1:0] data);
      case (idx)
        CFG_LOAD_DELTA:     load_delta = data;
        CFG_IMAGE_SIZE:     image_size = data[31:0];
        CFG_RELOC_DIR_SIZE: dir_size = data[31:0];
        default: ;
      endcase
    endfunction

    function void push(logic [31:0] t, logic [1:0] w, logic [63:0] a, status_e s, logic d);
      fixup_t f;
      f.target = t;
      f.width = w;
      f.addend = a;
      f.status = s;
      f.done = d;
      expected_fixups.push_back(f);
    endfunction

    function void raise_error(status_e s);
      halted = 1'b1;
      push('0, ACC_NONE, '0, s, 1'b1);
    endfunction

    function void note_halfword(logic [15:0] half, logic last);
      logic [11:0] off;
      logic [3:0]  typ;
      logic [1:0]  width;
      logic [63:0] addend;
      logic [32:0] sum;
      logic [32:0] reach;
      bit          have_fix;
      have_fix = 1'b0;
      width = ACC_NONE;
      addend = '0;
      sum = '0;
      reach = '0;
      if (halted) return;
      if (load_delta == '0) begin
        if (last) begin
          clear_parser();
          push('0, ACC_NONE, '0, ST_OK, 1'b1);
        end
        return;
      end
      case (phase)
        HDR_PAGE_LO: begin
          page_addr = {16'h0, half};
          phase = HDR_PAGE_HI;
        end
        HDR_PAGE_HI: begin
          page_addr[31:16] = half;
          phase = HDR_SIZE_LO;
        end
        HDR_SIZE_LO: begin
          block_size = {16'h0, half};
          phase = HDR_SIZE_HI;
        end
        HDR_SIZE_HI: begin
          block_size[31:16] = half;
          if (block_size < 32'd8 || block_size[0] || block_size > dir_size) begin
            raise_error(ST_BAD_SIZE);
            return;
          end
          entries_left = 31'((block_size - 32'd8) >> 1);
          phase = (entries_left != '0) ? HDR_ENTRIES : HDR_PAGE_LO;
        end
        default: begin
          off = half[11:0];
          typ = half[15:12];
          entries_left = entries_left - 1'b1;
          if (entries_left == '0) phase = HDR_PAGE_LO;
          case (typ)
            TYPE_ABSOLUTE: ;
            TYPE_HIGH: begin
              width = ACC_16;
              reach = 33'd2;
              addend = {48'h0, load_delta[31:16]};
            end
            TYPE_LOW: begin
              width = ACC_16;
              reach = 33'd2;
              addend = {48'h0, load_delta[15:0]};
            end
            TYPE_HIGHLOW: begin
              width = ACC_32;
              reach = 33'd4;
              addend = {32'h0, load_delta[31:0]};
            end
            TYPE_DIR64: begin
              width = ACC_64;
              reach = 33'd8;
              addend = load_delta;
            end
            default: begin
              raise_error(ST_BAD_TYPE);
              return;
            end
          endcase
          if (width != ACC_NONE) begin
            sum = {1'b0, page_addr} + {21'h0, off};
            if (sum + reach > {1'b0, image_size}) begin
              raise_error(ST_OUT_OF_BOUNDS);
              return;
            end
            have_fix = 1'b1;
          end
        end
      endcase
      if (last) begin
        if (phase != HDR_PAGE_LO) begin
          raise_error(ST_TRUNCATED);
          return;
        end
        clear_parser();
        if (have_fix) push(sum[31:0], width, addend, ST_OK, 1'b1);
        else push('0, ACC_NONE, '0, ST_OK, 1'b1);
      end else if (have_fix) begin
        push(sum[31:0], width, addend, ST_OK, 1'b0);
      end
    endfunction

    function void check_fixup(fixup_t got);
      fixup_t want;
      if (expected_fixups.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected result: target %h width %0d addend %h status %0d final %0d",
                   got.target, got.width, got.addend, got.status, got.done);
        return;
      end
      want = expected_fixups.pop_front();
      if (got.target !== want.target || got.width !== want.width ||
          got.addend !== want.addend || got.status !== want.status ||
          got.done !== want.done) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("result mismatch (target/width/addend/status/final): expected %h/%0d/%h/%0d/%0d, got %h/%0d/%h/%0d/%0d",
                   want.target, want.width, want.addend, want.status, want.done,
                   got.target, got.width, got.addend, got.status, got.done);
      end
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [DELTA_W-1:0]   cfg_data_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic [HALF_W-1:0]    rel_half_i = '0;
  logic                 region_end_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [ADDR_W-1:0]    target_addr_o;
  logic [1:0]           access_width_o;
  logic [DELTA_W-1:0]   addend_o;
  logic [2:0]           status_o;
  logic                 final_res_o;

  reloc_fixup_scoreboard fixup_sb = new();

  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic [31:0] cfg_img_now = '0;
  logic [31:0] cfg_dir_now = '0;

  pe_base_relocation_fixup_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .rel_half_i    (rel_half_i),
    .region_end_i  (region_end_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .target_addr_o (target_addr_o),
    .access_width_o(access_width_o),
    .addend_o      (addend_o),
    .status_o      (status_o),
    .final_res_o   (final_res_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && cfg_valid_i && cfg_ready_o) fixup_sb.write_reg(cfg_index_i, cfg_data_i);
    if (rst_ni && in_valid_i && in_ready_o) fixup_sb.note_halfword(rel_half_i, region_end_i);
    if (rst_ni && out_valid_o && out_ready_i)
      fixup_sb.check_fixup('{target_addr_o, access_width_o, addend_o, status_e'(status_o),
                             final_res_o});
  end

  function automatic logic [63:0] rand_delta();
    logic [63:0] v;
    v = {$urandom, $urandom};
    if (v == '0) v = 64'd1;
    return v;
  endfunction

  task automatic cfg_beat(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic write_regs(input logic [63:0] delta, input logic [31:0] img,
                            input logic [31:0] dir);
    cfg_beat(CFG_LOAD_DELTA, delta);
    cfg_beat(CFG_IMAGE_SIZE, {32'h0, img});
    cfg_beat(CFG_RELOC_DIR_SIZE, {32'h0, dir});
    cfg_valid_i <= 1'b0;
    cfg_img_now = img;
    cfg_dir_now = dir;
  endtask

  task automatic send_half(input logic [15:0] half, input logic last);
    int unsigned gap;
    gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 4) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rel_half_i <= half;
    region_end_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain_pipeline();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (fixup_sb.expected_fixups.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic send_block(input logic close_region, inout int beats);
    int unsigned n_max;
    int unsigned n;
    int unsigned reach;
    logic [31:0] page;
    logic [31:0] size;
    logic [3:0]  typ;
    logic [11:0] off;
    n_max = (cfg_dir_now >= 32) ? 12 : (cfg_dir_now - 8) / 2;
    n = $urandom_range(0, n_max);
    case ($urandom_range(0, 7))
      0: page = $urandom;
      1: page = '0;
      default: page = (cfg_img_now == '1) ? $urandom : $urandom_range(0, cfg_img_now);
    endcase
    size = 32'd8 + 2 * n;
    send_half(page[15:0], 1'b0);
    send_half(page[31:16], 1'b0);
    send_half(size[15:0], 1'b0);
    send_half(size[31:16], close_region && n == 0);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 4))
        0: typ = TYPE_ABSOLUTE;
        1: typ = TYPE_HIGH;
        2: typ = TYPE_LOW;
        3: typ = TYPE_HIGHLOW;
        default: typ = TYPE_DIR64;
      endcase
      case ($urandom_range(0, 7))
        0: off = 12'hFFF;
        1: off = '0;
        default: off = 12'($urandom_range(0, 4095));
      endcase
      case (typ)
        TYPE_HIGH, TYPE_LOW: reach = 2;
        TYPE_HIGHLOW: reach = 4;
        TYPE_DIR64: reach = 8;
        default: reach = 0;
      endcase
      // Entries that would patch past the image end become absolute ones.
      if ({32'h0, page} + 64'(off) + 64'(reach) > {32'h0, cfg_img_now}) typ = TYPE_ABSOLUTE;
      send_half({typ, off}, close_region && i == n - 1);
    end
    beats += 4 + n;
  endtask

  initial begin
    wait (cycle_count >= TIMEOUT_CYCLES);
    $display("FAIL");
    $finish;
  end

  initial begin
    logic [63:0] d;
    logic [31:0] img;
    logic [31:0] dir;
    logic [31:0] page;
    logic [31:0] size;
    logic [3:0]  bad_typ;
    int          beats;
    int unsigned n;
    int unsigned cut;
    int unsigned t;
    status_e     err;
    logic        close_last;
    logic [15:0] words[$];

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 19;
    recv_idle_pct = 58;
    write_regs(64'hFEDC_BA98_7654_3210, '1, '1);
    send_half(16'h1000, 1'b0);
    send_half(16'h0000, 1'b0);
    send_half(16'h0012, 1'b0);
    send_half(16'h0000, 1'b0);
    send_half({TYPE_ABSOLUTE, 12'hFFF}, 1'b0);
    send_half({TYPE_HIGH, 12'h000}, 1'b0);
    send_half({TYPE_LOW, 12'h123}, 1'b0);
    send_half({TYPE_HIGHLOW, 12'hABC}, 1'b0);
    send_half({TYPE_DIR64, 12'hFFF}, 1'b0);
    send_half(16'hF000, 1'b0);
    send_half(16'hFFFF, 1'b0);
    send_half(16'h000A, 1'b0);
    send_half(16'h0000, 1'b0);
    send_half({TYPE_HIGHLOW, 12'hFFB}, 1'b1);
    send_half(16'hFFFF, 1'b0);
    send_half(16'hFFFF, 1'b0);
    send_half(16'h0008, 1'b0);
    send_half(16'h0000, 1'b1);

    for (int p = 0; p < 9; p++) begin
      case (p / 3)
        0: begin
          send_idle_pct = 19;
          recv_idle_pct = 58;
        end
        1: begin
          send_idle_pct = 58;
          recv_idle_pct = 19;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      case (p)
        0, 8: begin
          d = rand_delta();
          img = '1;
          dir = '1;
        end
        1: begin
          d = '1;
          img = $urandom_range(32'h1000, 32'h40000);
          dir = $urandom_range(8, 64);
        end
        2, 7: begin
          d = '0;
          img = $urandom;
          dir = $urandom;
        end
        3: begin
          d = 64'd1;
          img = '0;
          dir = 32'd8;
        end
        4: begin
          d = rand_delta();
          img = $urandom_range(32'h1000, 32'h40000);
          dir = '1;
        end
        5: begin
          d = rand_delta();
          img = '1;
          dir = $urandom_range(8, 4096);
        end
        default: begin
          d = rand_delta();
          img = $urandom;
          dir = '1;
        end
      endcase
      drain_pipeline();
      write_regs(d, img, dir);
      if (d == '0) begin
        repeat (40) send_half(16'($urandom), $urandom_range(0, 5) == 0);
        send_half(16'($urandom), 1'b1);
      end else begin
        beats = 0;
        while (beats < PHASE_BEATS) send_block($urandom_range(0, 3) == 0, beats);
        send_block(1'b1, beats);
      end
    end

    drain_pipeline();
    send_idle_pct = 19;
    recv_idle_pct = 58;
    img = $urandom_range(32'h1000, 32'h40000);
    dir = 2 * $urandom_range(8, 256);
    write_regs(rand_delta(), img, dir);
    err = status_e'($urandom_range(1, 4));
    close_last = $urandom_range(0, 1);
    case (err)
      ST_BAD_TYPE: begin
        t = $urandom_range(4, 14);
        if (t >= TYPE_DIR64) t++;
        bad_typ = t[3:0];
        words = '{16'h0000, 16'h0000, 16'h000C, 16'h0000, {TYPE_HIGHLOW, 12'h010},
                  {bad_typ, 12'($urandom)}};
      end
      ST_BAD_SIZE: begin
        case ($urandom_range(0, 3))
          0: size = $urandom_range(0, 7);
          1: size = 2 * $urandom_range(4, 200) + 1;
          2: size = dir + 2 * $urandom_range(1, 1000);
          default: size = 32'hFFFF_FFFE;
        endcase
        page = $urandom;
        words = '{page[15:0], page[31:16], size[15:0], size[31:16]};
      end
      ST_OUT_OF_BOUNDS: begin
        page = img - 32'd3;
        words = '{page[15:0], page[31:16], 16'h000A, 16'h0000, {TYPE_HIGHLOW, 12'h000}};
      end
      default: begin
        n = $urandom_range(1, 4);
        size = 32'd8 + 2 * n;
        words = '{16'h0000, 16'h0000, size[15:0], size[31:16]};
        for (int i = 0; i < n; i++) words.push_back({TYPE_LOW, 4'h0, 8'($urandom)});
        cut = $urandom_range(1, 3 + n);
        while (words.size() > cut) void'(words.pop_back());
        close_last = 1'b1;
      end
    endcase
    foreach (words[i]) send_half(words[i], close_last && i == words.size() - 1);
    repeat (6) send_half(16'($urandom), $urandom_range(0, 1));

    drain_pipeline();
    if (fixup_sb.mismatches == 0 && fixup_sb.expected_fixups.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/prfu_pkg.sv
rtl/prfu_front.sv
rtl/prfu_queue.sv
rtl/prfu_back.sv
rtl/pe_base_relocation_fixup_unit.sv
verif/pe_base_relocation_fixup_unit_tb.sv
